### hdl/dpt64_pkg.sv
// Shared constants for the 64-bit deterministic primality test.
// No dependencies.
package dpt64_pkg;

    localparam int unsigned CandW = 63;
    localparam int unsigned NumSmall = 12;
    localparam int unsigned NumBases = 7;
    localparam int unsigned BitCntW = 6;

    typedef logic [CandW-1:0] t_word;

    function automatic t_word small_prime(input logic [3:0] idx);
        t_word v;
        v = '0;
        unique case (idx)
            4'd0: v = t_word'(2);
            4'd1: v = t_word'(3);
            4'd2: v = t_word'(5);
            4'd3: v = t_word'(7);
            4'd4: v = t_word'(11);
            4'd5: v = t_word'(13);
            4'd6: v = t_word'(17);
            4'd7: v = t_word'(19);
            4'd8: v = t_word'(23);
            4'd9: v = t_word'(29);
            4'd10: v = t_word'(31);
            4'd11: v = t_word'(37);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_word mr_base(input logic [2:0] idx);
        t_word v;
        v = '0;
        unique case (idx)
            3'd0: v = t_word'(2);
            3'd1: v = t_word'(325);
            3'd2: v = t_word'(9375);
            3'd3: v = t_word'(28178);
            3'd4: v = t_word'(450775);
            3'd5: v = t_word'(9780504);
            3'd6: v = t_word'(1795265022);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### hdl/dpt64_modmul.sv
// Bit-serial modular multiplier: one double-and-add step mod m per cycle.
// Depends on dpt64_pkg.
module dpt64_modmul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  dpt64_pkg::t_word   i_x,
    input  dpt64_pkg::t_word   i_y,
    input  dpt64_pkg::t_word   i_m,
    output logic               o_done,
    output dpt64_pkg::t_word   o_p
);

    logic                            r_busy, n_busy;
    logic [dpt64_pkg::BitCntW-1:0]   r_bit, n_bit;
    dpt64_pkg::t_word                r_acc, n_acc;
    dpt64_pkg::t_word                r_x, n_x;
    dpt64_pkg::t_word                r_y, n_y;
    logic                            r_done, n_done;
    logic [dpt64_pkg::CandW:0]       w_dbl, w_add;
    dpt64_pkg::t_word                w_d;

    always_comb begin
        // x, acc < m < 2^63, so sums fit in 64 bits
        w_dbl = {1'b0, r_acc} + {1'b0, r_acc};
        w_d = (w_dbl >= {1'b0, i_m}) ? dpt64_pkg::t_word'(w_dbl - {1'b0, i_m})
                                      : w_dbl[dpt64_pkg::CandW-1:0];
        w_add = {1'b0, w_d} + {1'b0, r_x};
        n_busy = r_busy;
        n_bit = r_bit;
        n_acc = r_acc;
        n_x = r_x;
        n_y = r_y;
        n_done = 1'b0;
        if (i_go) begin
            n_busy = 1'b1;
            n_bit = dpt64_pkg::BitCntW'(dpt64_pkg::CandW - 1);
            n_acc = '0;
            n_x = i_x;
            n_y = i_y;
        end else if (r_busy) begin
            if (r_y[r_bit])
                n_acc = (w_add >= {1'b0, i_m}) ? dpt64_pkg::t_word'(w_add - {1'b0, i_m})
                                                : w_add[dpt64_pkg::CandW-1:0];
            else
                n_acc = w_d;
            if (r_bit == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_bit = r_bit - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_bit <= n_bit;
        end
        r_acc <= n_acc;
        r_x <= n_x;
        r_y <= n_y;
    end

    assign o_done = r_done;
    assign o_p = r_acc;

endmodule

### hdl/deterministic_primality_test_64_top.sv
// Deterministic Miller-Rabin primality test for 63-bit candidates; needs dpt64_pkg, dpt64_modmul.
// Candidates below 2 go straight to the done state. Otherwise every step is one pass of the
// bit-serial unit: 12 trial remainders, then per base one reduction and up to 123 products
// (7 bases, 123 products each at most).
// Throughput: one candidate at a time; busy stays high until o_valid, the receiver cannot stall.
// Synchronous active-low reset returns the sequencer to idle with no result pending.
module deterministic_primality_test_64_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [62:0]            i_candidate,
    output logic                   o_valid,
    output logic                   o_prime_flag
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SIEVE, ST_SVWAIT, ST_SPLIT, ST_BASE, ST_BWAIT, ST_PSTEP,
        ST_PWAIT, ST_CHECK, ST_SQ, ST_SQWAIT, ST_DONE
    } t_state;

    t_state                          r_state;
    dpt64_pkg::t_word                r_n, r_d, r_e, r_acc, r_b, r_x;
    logic [dpt64_pkg::BitCntW-1:0]   r_s, r_r;
    logic [3:0]                      r_sp;      // trial prime index
    logic [2:0]                      r_bi;      // base index
    logic                            r_sqphase; // pow: 0 = acc*b, 1 = b*b
    logic                            r_flag, r_valid;

    logic                            w_go, w_mdone, w_last;
    dpt64_pkg::t_word                w_mx, w_my, w_mm, w_mp, w_p, w_nm1;

    // shared unit: x*y mod m, y consumed bit by bit, so y may exceed m
    dpt64_modmul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(w_go),
        .i_x(w_mx), .i_y(w_my), .i_m(w_mm), .o_done(w_mdone), .o_p(w_mp)
    );

    assign w_p = dpt64_pkg::small_prime(r_sp);
    assign w_nm1 = r_n - 1'b1;
    assign w_last = (r_bi == 3'(dpt64_pkg::NumBases - 1));

    // Operand select. Trial division runs 1*n mod p, base reduction 1*base mod n.
    // The modulus must hold for the whole pass, so it follows the state.
    always_comb begin
        w_go = 1'b0;
        w_mx = dpt64_pkg::t_word'(1);
        w_my = r_n;
        w_mm = r_n;
        unique case (r_state)
            ST_SIEVE: begin
                w_go = 1'b1;
                w_mm = w_p;
            end
            ST_SVWAIT: begin
                w_mm = w_p;
            end
            ST_BASE: begin
                w_go = 1'b1;
                w_my = dpt64_pkg::mr_base(r_bi);
            end
            ST_PSTEP: begin
                w_go = 1'b1;
                w_mx = r_sqphase ? r_b : r_acc;
                w_my = r_b;
            end
            ST_SQ: begin
                w_go = 1'b1;
                w_mx = r_x;
                w_my = r_x;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_DONE);
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_n <= i_candidate;
                        r_sp <= '0;
                        if (i_candidate < dpt64_pkg::t_word'(2)) begin
                            // zero and one are not prime
                            r_flag <= 1'b0;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_SIEVE;
                        end
                    end
                end
                ST_SIEVE: begin
                    r_state <= ST_SVWAIT;
                end
                ST_SVWAIT: begin
                    if (w_mdone) begin
                        if (w_mp == '0) begin
                            // small factor: prime only if n is that prime
                            r_flag <= (r_n == w_p);
                            r_state <= ST_DONE;
                        end else if (r_sp == 4'(dpt64_pkg::NumSmall - 1)) begin
                            r_d <= w_nm1;
                            r_s <= '0;
                            r_state <= ST_SPLIT;
                        end else begin
                            r_sp <= r_sp + 1'b1;
                            r_state <= ST_SIEVE;
                        end
                    end
                end
                ST_SPLIT: begin
                    // n is odd and above 37 here, so n-1 = d * 2^s with s >= 1
                    if (r_d[0]) begin
                        r_bi <= '0;
                        r_state <= ST_BASE;
                    end else begin
                        r_d <= r_d >> 1;
                        r_s <= r_s + 1'b1;
                    end
                end
                ST_BASE: begin
                    r_state <= ST_BWAIT;
                end
                ST_BWAIT: begin
                    if (w_mdone) begin
                        if (w_mp == '0) begin
                            // base is a multiple of n: skipped
                            if (w_last) begin
                                r_flag <= 1'b1;
                                r_state <= ST_DONE;
                            end else begin
                                r_bi <= r_bi + 1'b1;
                                r_state <= ST_BASE;
                            end
                        end else begin
                            r_b <= w_mp;
                            r_acc <= dpt64_pkg::t_word'(1);
                            r_e <= r_d;
                            r_sqphase <= 1'b0;  // d is odd
                            r_state <= ST_PSTEP;
                        end
                    end
                end
                ST_PSTEP: begin
                    r_state <= ST_PWAIT;
                end
                ST_PWAIT: begin
                    if (w_mdone) begin
                        if (!r_sqphase) begin
                            if (r_e[dpt64_pkg::CandW-1:1] == '0) begin
                                // last exponent bit: the final square is not needed
                                r_x <= w_mp;
                                r_state <= ST_CHECK;
                            end else begin
                                r_acc <= w_mp;
                                r_sqphase <= 1'b1;
                                r_state <= ST_PSTEP;
                            end
                        end else begin
                            r_b <= w_mp;
                            r_e <= r_e >> 1;
                            r_sqphase <= ~r_e[1];
                            r_state <= ST_PSTEP;
                        end
                    end
                end
                ST_CHECK: begin
                    if (r_x == dpt64_pkg::t_word'(1) || r_x == w_nm1) begin
                        if (w_last) begin
                            r_flag <= 1'b1;
                            r_state <= ST_DONE;
                        end else begin
                            r_bi <= r_bi + 1'b1;
                            r_state <= ST_BASE;
                        end
                    end else if (r_s <= dpt64_pkg::BitCntW'(1)) begin
                        r_flag <= 1'b0;
                        r_state <= ST_DONE;
                    end else begin
                        r_r <= dpt64_pkg::BitCntW'(1);
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_state <= ST_SQWAIT;
                end
                ST_SQWAIT: begin
                    if (w_mdone) begin
                        r_x <= w_mp;
                        if (w_mp == w_nm1) begin
                            if (w_last) begin
                                r_flag <= 1'b1;
                                r_state <= ST_DONE;
                            end else begin
                                r_bi <= r_bi + 1'b1;
                                r_state <= ST_BASE;
                            end
                        end else if (r_r + 1'b1 >= r_s) begin
                            // s-1 squares without reaching n-1: witness found
                            r_flag <= 1'b0;
                            r_state <= ST_DONE;
                        end else begin
                            r_r <= r_r + 1'b1;
                            r_state <= ST_SQ;
                        end
                    end
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign busy = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_prime_flag = r_flag;

endmodule

### tb/deterministic_primality_test_64_top_test.sv
// Testbench for deterministic_primality_test_64_top: drives 63-bit candidates and
// checks every prime flag against a 128-bit-product Miller-Rabin predictor.
// Depends on dpt64_pkg and the block's RTL.
module deterministic_primality_test_64_top_test;

    localparam logic [63:0] TbSmall [12] = '{
        64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17, 64'd19, 64'd23, 64'd29,
        64'd31, 64'd37
    };
    localparam logic [63:0] TbBase [7] = '{
        64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504, 64'd1795265022
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    dpt64_pkg::t_word     i_candidate;
    logic                 o_valid;
    logic                 o_prime_flag;

    // flags predicted for accepted candidates, oldest first
    logic                 flag_fifo[$];
    dpt64_pkg::t_word     cand_fifo[$];
    int unsigned          fail_count = 0;

    deterministic_primality_test_64_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_candidate (i_candidate),
        .o_valid     (o_valid),
        .o_prime_flag(o_prime_flag)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog timeout, long enough for well over a hundred worst-case
    // candidates.
    initial begin
        #500000000;
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor: full double-width products reduced mod n.
    // ---------------------------------------------------------------
    function automatic logic [63:0] mulmod(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] n);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p % {64'd0, n});
    endfunction

    function automatic logic [63:0] powmod(input logic [63:0] b, input logic [63:0] e,
                                           input logic [63:0] n);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] ex;
        acc = 64'd1;
        sq  = b % n;
        ex  = e;
        while (ex != 64'd0) begin
            if (ex[0]) acc = mulmod(acc, sq, n);
            sq = mulmod(sq, sq, n);
            ex = ex >> 1;
        end
        return acc;
    endfunction

    function automatic logic predict_prime(input dpt64_pkg::t_word cand);
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] x;
        int          s;
        logic        witness;
        n = {1'b0, cand};
        if (n < 64'd2) return 1'b0;
        for (int i = 0; i < int'(dpt64_pkg::NumSmall); i++) begin
            if (n % TbSmall[i] == 64'd0) return n == TbSmall[i];
        end
        d = n - 64'd1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        for (int i = 0; i < int'(dpt64_pkg::NumBases); i++) begin
            // base divisible by n: skipped
            if (TbBase[i] % n == 64'd0) continue;
            x = powmod(TbBase[i], d, n);
            if (x == 64'd1 || x == n - 64'd1) continue;
            witness = 1'b1;
            for (int r = 1; r < s; r++) begin
                x = mulmod(x, x, n);
                if (x == n - 64'd1) begin
                    witness = 1'b0;
                    break;
                end
            end
            if (witness) return 1'b0;
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus and checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // One transfer; the sender stays idle with probability idle_pct per cycle first.
    task automatic send_candidate(input dpt64_pkg::t_word cand, input int unsigned idle_pct);
        // step off the edge of the previous transfer; the block is busy then anyway
        @(posedge i_clk);
        while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        start       <= 1'b1;
        i_candidate <= cand;
        // busy read here is the pre-edge value, so the loop exits on the accepting edge
        do @(posedge i_clk); while (busy);
        flag_fifo = {flag_fifo, predict_prime(cand)};
        cand_fifo = {cand_fifo, cand};
        start       <= 1'b0;
        i_candidate <= dpt64_pkg::t_word'({$urandom, $urandom});
    endtask

    task automatic wait_drained();
        while (flag_fifo.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (flag_fifo.size() == 0) begin
                report_mismatch("result with no candidate outstanding");
            end else begin
                if (o_prime_flag !== flag_fifo[0])
                    report_mismatch($sformatf("candidate %0d: flag %b, expected %b",
                                              cand_fifo[0], o_prime_flag, flag_fifo[0]));
                void'(flag_fifo.pop_front());
                void'(cand_fifo.pop_front());
            end
        end
    end

    task automatic test_directed();
        dpt64_pkg::t_word list[$];
        list = '{
            dpt64_pkg::t_word'(0), dpt64_pkg::t_word'(1), dpt64_pkg::t_word'(2),
            dpt64_pkg::t_word'(3), dpt64_pkg::t_word'(4),
            dpt64_pkg::t_word'(37), dpt64_pkg::t_word'(41), dpt64_pkg::t_word'(74),
            dpt64_pkg::t_word'(1369),
            dpt64_pkg::t_word'(2047),                     // base-2 strong pseudoprime
            dpt64_pkg::t_word'(561),                      // Carmichael, factor 3
            dpt64_pkg::t_word'(1795265022), dpt64_pkg::t_word'(64'd3215031751),
            dpt64_pkg::t_word'(64'd1000006000009),         // square of a prime
            dpt64_pkg::t_word'(64'd341550071728321),
            dpt64_pkg::t_word'(64'd3825123056546413051),
            dpt64_pkg::t_word'(64'd2305843009213693951),   // 2^61-1, prime
            dpt64_pkg::t_word'(64'd9223372036854775783),   // largest 63-bit prime
            dpt64_pkg::t_word'(64'h7FFF_FFFF_FFFF_FFFF),
            dpt64_pkg::t_word'(64'h5555_5555_5555_5555),
            dpt64_pkg::t_word'(64'h2AAA_AAAA_AAAA_AAAB)
        };
        foreach (list[i]) send_candidate(list[i], 0);
    endtask

    function automatic dpt64_pkg::t_word random_candidate();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) return dpt64_pkg::t_word'({$urandom, $urandom});
        if (pick < 70) return dpt64_pkg::t_word'($urandom_range(1 << 20, 0) | 1);
        if (pick < 90) return dpt64_pkg::t_word'({32'd0, $urandom | 32'd1});
        return dpt64_pkg::t_word'(64'h7FFF_FFFF_FFFF_FFFF >> $urandom_range(62));
    endfunction

    task automatic test_random(input int unsigned n_items, input int unsigned idle_pct);
        repeat (n_items) send_candidate(random_candidate(), idle_pct);
    endtask

    // Sender holds off until the block has delivered everything.
    task automatic test_drain_pause();
        wait_drained();
        repeat (5) @(posedge i_clk);
        send_candidate(dpt64_pkg::t_word'(64'd2305843009213693951), 0);
        send_candidate(random_candidate(), 0);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_candidate = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(20, 0);
        test_random(20, 51);
        test_drain_pause();
        test_random(20, 27);
        test_random(20, 0);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
